>>> rtl/satok_pkg.sv
// shared types, character codes and register indexes for the argument tokenizer
package satok_pkg;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 2'd1;

  localparam logic [15:0] SIZE_LIMIT_RST = 16'hFFFF;

  // result queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef enum logic [1:0] {
    QUOTE_NONE,
    QUOTE_SINGLE,
    QUOTE_DOUBLE
  } quote_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        arg_end;
    logic [15:0] arg_count;
    logic        overflow;
    logic        string_done;
    logic        last;
  } result_t;

  // up to two results produced by one input transaction
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
  } cfg_wr_t;

  function automatic result_t make_res(input logic [7:0] b, input logic valid,
                                       input logic end_flag, input logic [15:0] count,
                                       input logic ovf, input logic done);
    result_t r;
    r.out_byte    = valid ? b : 8'h00;
    r.byte_valid  = valid;
    r.arg_end     = end_flag;
    r.arg_count   = count;
    r.overflow    = ovf;
    r.string_done = done;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/satok_ifs.sv
// handshake channel interfaces: text input, result output, configuration write

interface satok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface satok_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        arg_end;
  logic [15:0] arg_count;
  logic        overflow;
  logic        string_done;
  logic        last;
  modport source (output valid, output out_byte, output byte_valid, output arg_end,
                  output arg_count, output overflow, output string_done, output last,
                  input ready);
  modport sink (input valid, input out_byte, input byte_valid, input arg_end,
                input arg_count, input overflow, input string_done, input last,
                output ready);
endinterface

interface satok_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/shell_argument_tokenizer_top.sv
// top level of the shell-style argument tokenizer
//
// Channels: text_i carries one command byte per transaction, a zero byte
// ends the string. result_o carries result items (argument byte, argument
// end, overflow, end of string), with last set on the final result of each
// input byte. cfg_i writes base_size (index 0) and size_limit (index 1);
// it is always ready; the user must write it only while the block is idle,
// which the block does not enforce. Results wait in a registered queue.
// Throughput: one input byte per cycle while each byte yields at most one
// result; an escaped ordinary character yields two results, and the output
// side then sets the pace at one result per cycle. The pace is set by the
// four-entry result queue, which takes a byte whenever two entries are free.
// Reset: state returns to outside quotes, no argument open, count zero,
// base_size 0 and size_limit 65535; the queue is emptied.
// Receiver stall: results wait in the queue and text_i.ready drops once
// fewer than two entries are free; nothing is lost or repeated.
module shell_argument_tokenizer_top import satok_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  satok_in_if.sink    text_i,
  satok_out_if.source result_o,
  satok_cfg_if.sink   cfg_i
);

  cfg_wr_t cfg_wr;
  push_t   push;
  result_t head;
  logic    room;
  logic    head_valid;
  logic    in_accept;
  logic    pop;

  // handshakes
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.en    = cfg_i.valid;
  assign cfg_wr.idx   = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;
  assign text_i.ready = room;
  assign in_accept    = text_i.valid && room;
  assign pop          = head_valid && result_o.ready;

  satok_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .in_accept_i (in_accept),
    .text_byte_i (text_i.text_byte),
    .push_o      (push)
  );

  satok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // result channel
  assign result_o.valid       = head_valid;
  assign result_o.out_byte    = head.out_byte;
  assign result_o.byte_valid  = head.byte_valid;
  assign result_o.arg_end     = head.arg_end;
  assign result_o.arg_count   = head.arg_count;
  assign result_o.overflow    = head.overflow;
  assign result_o.string_done = head.string_done;
  assign result_o.last        = head.last;

endmodule

>>> rtl/satok_core.sv
// parser state, size accounting and per-byte result generation
module satok_core import satok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_wr_i,
  input  logic    in_accept_i,
  input  logic [7:0] text_byte_i,
  output push_t   push_o
);

  logic [15:0] base_q, base_d;
  logic [15:0] limit_q, limit_d;
  quote_e      quote_q, quote_d;
  logic        esc_q, esc_d;
  logic        in_arg_q, in_arg_d;
  logic [16:0] total_q, total_d;
  logic [15:0] completed_q, completed_d;
  logic        stopped_q, stopped_d;

  logic [16:0] t1, t2, lim17;
  logic        ovf1, ovf2;
  logic [15:0] cnt_inc;
  logic        special;
  logic        act_put, act_pair, act_end;
  push_t       push;

  // size checks for one and two charges
  assign t1      = total_q + 17'd1;
  assign t2      = total_q + 17'd2;
  assign lim17   = {1'b0, limit_q};
  assign ovf1    = t1 > lim17;
  assign ovf2    = t2 > lim17;
  assign cnt_inc = completed_q + 16'd1;
  assign special = (text_byte_i == CH_BSLASH) || (text_byte_i == CH_SQUOTE) ||
                   (text_byte_i == CH_DQUOTE) || (text_byte_i == CH_SPACE) ||
                   (text_byte_i == CH_TAB);

  // decode the byte and build results and next state
  always_comb begin
    base_d      = base_q;
    limit_d     = limit_q;
    quote_d     = quote_q;
    esc_d       = esc_q;
    in_arg_d    = in_arg_q;
    total_d     = total_q;
    completed_d = completed_q;
    stopped_d   = stopped_q;
    act_put     = 1'b0;
    act_pair    = 1'b0;
    act_end     = 1'b0;
    push        = '0;

    if (in_accept_i) begin
      if (text_byte_i == CH_NUL) begin
        // end of string: close any open argument, then restart
        push.push0 = 1'b1;
        push.res0  = make_res(8'h00, 1'b0, 1'b0, completed_q, stopped_q, 1'b1);
        if (!stopped_q && in_arg_q) begin
          if (ovf1) begin
            push.res0 = make_res(8'h00, 1'b0, 1'b0, completed_q, 1'b1, 1'b1);
          end else begin
            push.res0 = make_res(8'h00, 1'b0, 1'b1, cnt_inc, 1'b0, 1'b1);
          end
        end
        quote_d     = QUOTE_NONE;
        esc_d       = 1'b0;
        in_arg_d    = 1'b0;
        total_d     = {1'b0, base_q};
        completed_d = 16'd0;
        stopped_d   = 1'b0;
      end else if (!stopped_q) begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (special) begin
            act_put = 1'b1;
          end else begin
            act_pair = 1'b1;
          end
        end else begin
          case (text_byte_i)
            CH_BSLASH: begin
              esc_d = 1'b1;
            end
            CH_SQUOTE: begin
              if (quote_q == QUOTE_DOUBLE) begin
                act_put = 1'b1;
              end else begin
                quote_d = (quote_q == QUOTE_SINGLE) ? QUOTE_NONE : QUOTE_SINGLE;
              end
            end
            CH_DQUOTE: begin
              if (quote_q == QUOTE_SINGLE) begin
                act_put = 1'b1;
              end else begin
                quote_d = (quote_q == QUOTE_DOUBLE) ? QUOTE_NONE : QUOTE_DOUBLE;
              end
            end
            CH_SPACE, CH_TAB: begin
              if (quote_q != QUOTE_NONE) begin
                act_put = 1'b1;
              end else if (in_arg_q) begin
                act_end = 1'b1;
              end
            end
            default: begin
              act_put = 1'b1;
            end
          endcase
        end
      end
    end

    // emit one character
    if (act_put) begin
      push.push0 = 1'b1;
      if (ovf1) begin
        push.res0 = make_res(8'h00, 1'b0, 1'b0, completed_q, 1'b1, 1'b0);
        stopped_d = 1'b1;
      end else begin
        push.res0 = make_res(text_byte_i, 1'b1, 1'b0, completed_q, 1'b0, 1'b0);
        total_d   = t1;
        in_arg_d  = 1'b1;
      end
    end

    // escaped ordinary character keeps its backslash
    if (act_pair) begin
      push.push0 = 1'b1;
      if (ovf1) begin
        push.res0 = make_res(8'h00, 1'b0, 1'b0, completed_q, 1'b1, 1'b0);
        stopped_d = 1'b1;
      end else begin
        push.res0  = make_res(CH_BSLASH, 1'b1, 1'b0, completed_q, 1'b0, 1'b0);
        in_arg_d   = 1'b1;
        push.push1 = 1'b1;
        if (ovf2) begin
          push.res1 = make_res(8'h00, 1'b0, 1'b0, completed_q, 1'b1, 1'b0);
          stopped_d = 1'b1;
          total_d   = t1;
        end else begin
          push.res1 = make_res(text_byte_i, 1'b1, 1'b0, completed_q, 1'b0, 1'b0);
          total_d   = t2;
        end
      end
    end

    // separator closes the argument
    if (act_end) begin
      push.push0 = 1'b1;
      in_arg_d   = 1'b0;
      if (ovf1) begin
        push.res0 = make_res(8'h00, 1'b0, 1'b0, completed_q, 1'b1, 1'b0);
        stopped_d = 1'b1;
      end else begin
        push.res0   = make_res(8'h00, 1'b0, 1'b1, cnt_inc, 1'b0, 1'b0);
        completed_d = cnt_inc;
        total_d     = t1;
      end
    end

    // mark the final result of the transaction
    push.res0.last = !push.push1;
    push.res1.last = 1'b1;

    // configuration writes
    if (cfg_wr_i.en) begin
      case (cfg_wr_i.idx)
        CFG_BASE_SIZE: begin
          base_d  = cfg_wr_i.data;
          total_d = {1'b0, cfg_wr_i.data};
        end
        CFG_SIZE_LIMIT: begin
          limit_d = cfg_wr_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 16'd0;
      limit_q     <= SIZE_LIMIT_RST;
      quote_q     <= QUOTE_NONE;
      esc_q       <= 1'b0;
      in_arg_q    <= 1'b0;
      total_q     <= 17'd0;
      completed_q <= 16'd0;
      stopped_q   <= 1'b0;
    end else begin
      base_q      <= base_d;
      limit_q     <= limit_d;
      quote_q     <= quote_d;
      esc_q       <= esc_d;
      in_arg_q    <= in_arg_d;
      total_q     <= total_d;
      completed_q <= completed_d;
      stopped_q   <= stopped_d;
    end
  end

  assign push_o = push;

  // results only come from an accepted byte
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push0 |-> in_accept_i)
    else $error("result pushed without an input transaction");

  // a stopped parser ignores everything but the zero byte
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept_i && stopped_q && (text_byte_i != CH_NUL)) |-> !push.push0)
    else $error("stopped parser produced a result");

  // the zero byte returns the parser to its start state
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept_i && (text_byte_i == CH_NUL)) |=>
      ((completed_q == 16'd0) && !stopped_q && !in_arg_q && !esc_q))
    else $error("parser state not cleared after end of string");

endmodule

>>> rtl/satok_fifo.sv
// small result queue taking up to two results per cycle and giving one
module satok_fifo import satok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   wr_next;

  assign wr_next = wr_q + PTR_W'(1);
  assign wr_d    = wr_q + PTR_W'(push_i.push0) + PTR_W'(push_i.push1);
  assign rd_d    = rd_q + PTR_W'(pop_i);
  assign count_d = count_q + CNT_W'(push_i.push0) + CNT_W'(push_i.push1) - CNT_W'(pop_i);

  // room for a transaction that yields two results
  assign room_o  = count_q <= CNT_W'(FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed without the first");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push0 |-> room_o)
    else $error("result pushed while queue lacked room");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the shell-style argument tokenizer
`timescale 1ns / 100ps

module testbench;
  import satok_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 720;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 4;

  typedef enum int unsigned {
    RX_FREE,
    RX_COIN,
    RX_LIGHT,
    RX_PATTERN
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  satok_in_if  text_if ();
  satok_out_if res_if ();
  satok_cfg_if cfg_if ();

  shell_argument_tokenizer_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tokenizer state as the block should hold it
  logic [15:0] base_s;
  logic [15:0] limit_s;
  quote_e      quote_s;
  logic        esc_s;
  logic        in_arg_s;
  logic [16:0] used_s;
  logic [15:0] args_s;
  logic        halted_s;

  // tokens still due from the block, oldest first
  result_t due_tokens[$];
  result_t held_tok;
  logic    have_tok;

  int unsigned live_bytes    = 0;
  int unsigned commands_done = 0;
  int unsigned tokens_seen   = 0;
  int unsigned overflows     = 0;
  int unsigned reg_writes    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // sender and receiver pacing
  int unsigned burst_left  = 0;
  logic        steady_send = 1'b0;
  int unsigned hold_left   = 0;
  rx_mode_e    rx_mode     = RX_FREE;
  int unsigned rx_left     = 0;
  int unsigned rx_tick     = 0;

  result_t got_tok;
  result_t want_tok;

  function automatic void restart_split();
    quote_s  = QUOTE_NONE;
    esc_s    = 1'b0;
    in_arg_s = 1'b0;
    used_s   = {1'b0, base_s};
    args_s   = '0;
    halted_s = 1'b0;
  endfunction

  // queue a token; the previous one is final only once another follows
  function automatic void emit_token(input logic [7:0] b, input logic v, input logic e,
                                     input logic o, input logic d);
    if (have_tok) due_tokens.push_back(held_tok);
    held_tok.out_byte    = v ? b : 8'h00;
    held_tok.byte_valid  = v;
    held_tok.arg_end     = e;
    held_tok.arg_count   = args_s;
    held_tok.overflow    = o;
    held_tok.string_done = d;
    held_tok.last        = 1'b0;
    have_tok = 1'b1;
  endfunction

  // one unit of message size; exceeding the limit halts parsing
  function automatic logic charge_unit();
    if (32'(used_s) + 1 > 32'(limit_s)) begin
      halted_s = 1'b1;
      return 1'b0;
    end
    used_s = used_s + 17'd1;
    return 1'b1;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    if (halted_s) return;
    if (!charge_unit()) begin
      emit_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
      return;
    end
    in_arg_s = 1'b1;
    emit_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void close_arg(input logic done);
    if (charge_unit()) begin
      args_s = args_s + 16'd1;
      emit_token(8'h00, 1'b0, 1'b1, 1'b0, done);
    end else begin
      emit_token(8'h00, 1'b0, 1'b0, 1'b1, done);
    end
    in_arg_s = 1'b0;
  endfunction

  function automatic logic escapable(input logic [7:0] c);
    return c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE ||
           c == CH_SPACE || c == CH_TAB;
  endfunction

  // tokens caused by one accepted byte
  function automatic void split_byte(input logic [7:0] c);
    live_bytes++;
    have_tok = 1'b0;
    if (c == CH_NUL) begin
      esc_s = 1'b0;
      if (halted_s) emit_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      else if (in_arg_s) close_arg(1'b1);
      else emit_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      restart_split();
      commands_done++;
    end else if (halted_s) begin
      // bytes are dropped until the terminator
    end else if (esc_s) begin
      esc_s = 1'b0;
      if (!escapable(c)) put_char(CH_BSLASH);
      put_char(c);
    end else if (c == CH_BSLASH) begin
      esc_s = 1'b1;
    end else if (c == CH_SQUOTE) begin
      if (quote_s == QUOTE_DOUBLE) put_char(c);
      else if (quote_s == QUOTE_SINGLE) quote_s = QUOTE_NONE;
      else quote_s = QUOTE_SINGLE;
    end else if (c == CH_DQUOTE) begin
      if (quote_s == QUOTE_SINGLE) put_char(c);
      else if (quote_s == QUOTE_DOUBLE) quote_s = QUOTE_NONE;
      else quote_s = QUOTE_DOUBLE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (quote_s != QUOTE_NONE) put_char(c);
      else if (in_arg_s) close_arg(1'b0);
    end else begin
      put_char(c);
    end
    if (have_tok) begin
      held_tok.last = 1'b1;
      due_tokens.push_back(held_tok);
    end
  endfunction

  function automatic string fmt_token(input result_t r);
    return $sformatf("byte=%02h bv=%b end=%b cnt=%0d ovf=%b done=%b last=%b",
                     r.out_byte, r.byte_valid, r.arg_end, r.arg_count, r.overflow,
                     r.string_done, r.last);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_tok.out_byte    = res_if.out_byte;
      got_tok.byte_valid  = res_if.byte_valid;
      got_tok.arg_end     = res_if.arg_end;
      got_tok.arg_count   = res_if.arg_count;
      got_tok.overflow    = res_if.overflow;
      got_tok.string_done = res_if.string_done;
      got_tok.last        = res_if.last;
      tokens_seen++;
      if (got_tok.overflow) overflows++;
      if (due_tokens.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result: %s", fmt_token(got_tok));
      end else begin
        want_tok = due_tokens.pop_front();
        if (got_tok !== want_tok) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t: expected %s", $time, fmt_token(want_tok));
            $display("                  actual   %s", fmt_token(got_tok));
          end
        end
      end
    end
  end

  // receiver: long hold-offs on request, otherwise a changing stall pattern
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_tick++;
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 256);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:    res_if.ready <= 1'b1;
          RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
          RX_LIGHT:   res_if.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: res_if.ready <= (rx_tick % 5 < 2);
          default:    res_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one byte transaction, paced in bursts; entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
    split_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic terminate);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (terminate) send_byte(CH_NUL);
  endtask

  // stop sending and wait for every due token
  task automatic drain();
    text_if.valid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write transaction
  task automatic cfg_send(input logic [1:0] idx, input logic [15:0] value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_BASE_SIZE) begin
      base_s = value;
      used_s = {1'b0, value};
    end else if (idx == CFG_SIZE_LIMIT) begin
      limit_s = value;
    end
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] base, input logic [15:0] limit);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_send(CFG_BASE_SIZE, base);
    cfg_send(CFG_SIZE_LIMIT, limit);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 9))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_SQUOTE;
      3: return CH_DQUOTE;
      4: return CH_BSLASH;
      5, 6: return 8'($urandom_range(1, 255));
      default: return word_char();
    endcase
  endfunction

  // one command: mostly words with quoting and escapes, some pure noise
  task automatic send_random_command();
    logic [7:0]  cmd[$];
    int unsigned words;
    int unsigned len;
    logic [7:0]  quote;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(0, 12);
      repeat (len) cmd.push_back(noise_char());
    end else begin
      words = $urandom_range(1, 4);
      repeat (words) begin
        repeat ($urandom_range(0, 2)) cmd.push_back($urandom_range(0, 2) == 0 ? CH_TAB : CH_SPACE);
        len = $urandom_range(1, 6);
        case ($urandom_range(0, 4))
          0: repeat (len) cmd.push_back(word_char());
          1, 2: begin
            // quoted word, the other quote and blanks literal inside, closing sometimes lost
            quote = ($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE;
            cmd.push_back(quote);
            repeat (len) begin
              case ($urandom_range(0, 5))
                0: cmd.push_back(quote == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                1: cmd.push_back(CH_SPACE);
                2: cmd.push_back(CH_TAB);
                default: cmd.push_back(word_char());
              endcase
            end
            if ($urandom_range(0, 5) != 0) cmd.push_back(quote);
          end
          3: repeat (len) begin
            cmd.push_back(CH_BSLASH);
            cmd.push_back($urandom_range(0, 1) == 0 ? noise_char() : word_char());
          end
          default: begin
            cmd.push_back(CH_DQUOTE);
            cmd.push_back(CH_DQUOTE);
          end
        endcase
      end
      if ($urandom_range(0, 5) == 0) cmd.push_back(CH_BSLASH);
    end
    foreach (cmd[i]) send_byte(cmd[i]);
    send_byte(CH_NUL);
  endtask

  // quoting, blanks, escaped first character, trailing backslash, empty quotes
  task automatic test_quoting();
    send_text("\"\"", 1'b1);
    send_text("\\q 'a\"b'\t\"c'\"\\", 1'b1);
  endtask

  // escaped specials, byte extremes, unclosed quote
  task automatic test_escapes();
    send_text("\\\\\\'\\ ", 1'b0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_text("'u", 1'b1);
  endtask

  // overflow, ignored bytes after it, limit below base, register extremes
  task automatic test_size_limit();
    set_limits(16'd2, 16'd4);
    send_text("ab cd", 1'b1);
    set_limits(16'd9, 16'd3);
    send_text("x", 1'b1);
    set_limits(16'hFFFF, 16'hFFFF);
    send_text("z", 1'b1);
    set_limits(16'd0, 16'd1);
    send_text("y", 1'b1);
    set_limits(16'd0, SIZE_LIMIT_RST);
  endtask

  // receiver holds off while two-token escapes keep coming
  task automatic test_backpressure();
    drain();
    steady_send = 1'b1;
    hold_left   = 80;
    for (int i = 0; i < 24; i++) begin
      send_byte(CH_BSLASH);
      send_byte(8'h61 + 8'(i % 26));
    end
    send_byte(CH_NUL);
    steady_send = 1'b0;
    drain();
  endtask

  // sender pauses mid-command with an escape open
  task automatic test_pause();
    send_text("ab\\", 1'b0);
    drain();
    send_text("c d", 1'b1);
  endtask

  task automatic test_random();
    int unsigned start_live;
    logic [15:0] b;
    logic [15:0] l;
    start_live = live_bytes;
    while (live_bytes - start_live < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin b = 16'd0; l = SIZE_LIMIT_RST; end
        3, 4, 5: begin
          b = 16'($urandom_range(0, 10));
          l = b + 16'($urandom_range(5, 40));
        end
        6: begin b = 16'($urandom); l = 16'($urandom_range(1, 65535)); end
        7: begin b = 16'hFFFF; l = 16'hFFFF; end
        8: begin b = 16'd0; l = 16'd1; end
        default: begin b = 16'($urandom_range(20, 100)); l = 16'($urandom_range(1, 19)); end
      endcase
      set_limits(b, l);
      repeat ($urandom_range(4, 10)) send_random_command();
    end
    drain();
  endtask

  initial begin
    rst_ni            = 1'b0;
    text_if.valid     = 1'b0;
    text_if.text_byte = CH_NUL;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_BASE_SIZE;
    cfg_if.data       = 16'd0;
    base_s            = 16'd0;
    limit_s           = SIZE_LIMIT_RST;
    have_tok          = 1'b0;
    restart_split();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_quoting();
    test_escapes();
    test_size_limit();
    test_backpressure();
    test_pause();
    test_random();

    $display("covered %0d bytes in %0d commands, %0d results checked (%0d with overflow)",
             live_bytes, commands_done, tokens_seen, overflows);
    $display("%0d register writes, %0d failures", reg_writes, fail_count);
    if (fail_count == 0 && due_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
